// ===== sv/lmu_pkg.sv =====
`default_nettype none
package lmu_pkg;

	localparam int POSE_DEPTH_DEF = 64;
	localparam int ROW_W          = 54;
	localparam int ELEM_W         = 18;
	localparam int VEC_W          = 32;
	localparam int STAMP_W        = 48;
	localparam int OFF_W          = 49;
	localparam int ACT_W          = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 54;
	localparam int QUEUE_DEPTH    = 2;
	localparam int PROD_W         = ELEM_W + VEC_W;
	localparam int SUM_W          = PROD_W + 2;

	localparam logic [ACT_W-1:0] ACT_START = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POSE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_POINT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROT0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TY    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TZ    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BEGIN = 3'd6;

	typedef logic [2:0][ROW_W-1:0] mat_t;
	typedef logic [2:0][VEC_W-1:0] vec3_t;

	typedef struct packed {
		mat_t  rot;
		vec3_t trans;
	} pose_t;

	typedef struct packed {
		pose_t            pose;
		logic [OFF_W-1:0] offset;
	} pose_ent_t;

	typedef struct packed {
		logic  comp;
		vec3_t pt;
		pose_t pk;
		pose_t pw;
	} job_t;

	// element (i,j) of m, or of m transposed
	function automatic logic signed [ELEM_W-1:0] mat_elem(mat_t m, logic [1:0] i,
			logic [1:0] j, logic tr);
		logic [1:0]       r;
		logic [1:0]       c;
		logic [ROW_W-1:0] row;
		r = tr ? j : i;
		c = tr ? i : j;
		row = m[r];
		return $signed(row[ELEM_W*c +: ELEM_W]);
	endfunction

	function automatic logic [VEC_W-1:0] sat_add(logic [VEC_W-1:0] a, logic [VEC_W-1:0] b,
			logic sub);
		logic signed [VEC_W+1:0] ea;
		logic signed [VEC_W+1:0] eb;
		logic signed [VEC_W+1:0] s;
		ea = $signed({{2{a[VEC_W-1]}}, a});
		eb = $signed({{2{b[VEC_W-1]}}, b});
		s = sub ? (ea - eb) : (ea + eb);
		if (s[VEC_W+1:VEC_W-1] == 3'b000 || s[VEC_W+1:VEC_W-1] == 3'b111)
			return s[VEC_W-1:0];
		return s[VEC_W+1] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
	endfunction

	// 36-bit rounded dot product down to 32 bits
	function automatic logic [VEC_W-1:0] sat_narrow(logic [SUM_W-17:0] v);
		logic [SUM_W-16-VEC_W:0] top;
		top = v[SUM_W-17:VEC_W-1];
		if (top == '0 || top == '1)
			return v[VEC_W-1:0];
		return v[SUM_W-17] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
	endfunction

endpackage
`default_nettype wire

// ===== sv/lmu_ram.sv =====
`default_nettype none
module lmu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/lmu_fifo.sv =====
`default_nettype none
module lmu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  not_empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue underflow");
endmodule
`default_nettype wire

// ===== sv/lmu_front.sv =====
`default_nettype none
module lmu_front #(
	parameter int POSE_DEPTH = lmu_pkg::POSE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lmu_pkg::ACT_W-1:0]     action,
	input  wire lmu_pkg::pose_t                in_pose,
	input  wire logic [lmu_pkg::STAMP_W-1:0]   stamp,
	input  wire logic [lmu_pkg::STAMP_W-1:0]   scan_begin,
	output logic                               push,
	output lmu_pkg::job_t                      job,
	input  wire logic                          q_full
);
	import lmu_pkg::*;

	localparam int AW = (POSE_DEPTH > 1) ? $clog2(POSE_DEPTH) : 1;
	localparam int CW = $clog2(POSE_DEPTH + 1);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_RD   = 2'd1;
	localparam logic [1:0] F_CMP  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0]         fst_q;
	logic [CW-1:0]      cnt_q;   // poses loaded
	logic [CW-1:0]      cur_q;   // cursor plus one, zero means no pose
	logic               comp_q;
	vec3_t              pt_q;
	logic [STAMP_W-1:0] t_q;
	pose_t              w_q;     // newest pose, also held outside the RAM

	logic      accept;
	logic      we;
	logic      re;
	pose_ent_t wdata;
	pose_ent_t rdata;
	logic      later;

	assign in_ready = (fst_q == F_IDLE);
	assign accept   = in_valid && in_ready;
	assign we       = accept && (action == ACT_POSE) && (cnt_q < CW'(POSE_DEPTH));
	assign re       = (fst_q == F_RD) && (cur_q != '0);

	always_comb begin
		wdata.pose   = in_pose;
		wdata.offset = {1'b0, stamp} - {1'b0, scan_begin};
	end

	assign later = $signed({2'b00, t_q}) > $signed({rdata.offset[OFF_W-1], rdata.offset});

	lmu_ram #(.WIDTH($bits(pose_ent_t)), .DEPTH(POSE_DEPTH)) u_pose_ram (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(wdata),
		.re   (re),
		.raddr(AW'(cur_q - 1'b1)),
		.rdata(rdata)
	);

	assign push = (fst_q == F_PUSH) && !q_full;

	always_comb begin
		job.comp = comp_q;
		job.pt   = pt_q;
		job.pk   = rdata.pose;
		job.pw   = w_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_q <= in_pose.trans;
			t_q  <= stamp;
		end
		if (we)
			w_q <= in_pose;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q  <= F_IDLE;
			cnt_q  <= '0;
			cur_q  <= '0;
			comp_q <= 1'b0;
		end else begin
			case (fst_q)
				F_IDLE: begin
					if (accept) begin
						case (action)
							ACT_START: begin
								cnt_q <= '0;
								cur_q <= '0;
							end
							ACT_POSE: begin
								if (we) begin
									cnt_q <= cnt_q + 1'b1;
									cur_q <= cnt_q + 1'b1;
								end
							end
							ACT_POINT: fst_q <= F_RD;
							default: ;
						endcase
					end
				end
				F_RD: begin
					if (cur_q == '0) begin
						comp_q <= 1'b0;
						fst_q  <= F_PUSH;
					end else begin
						fst_q <= F_CMP;
					end
				end
				F_CMP: begin
					if (later) begin
						comp_q <= 1'b1;
						fst_q  <= F_PUSH;
					end else begin
						cur_q <= cur_q - 1'b1;
						fst_q <= F_RD;
					end
				end
				F_PUSH: begin
					if (!q_full)
						fst_q <= F_IDLE;
				end
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	a_cur_in_table: assert property (@(posedge clk) disable iff (!arst_n) cur_q <= cnt_q)
		else $error("cursor beyond pose count");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
			cnt_q <= CW'(POSE_DEPTH))
		else $error("pose count beyond table depth");
endmodule
`default_nettype wire

// ===== sv/lmu_back.sv =====
`default_nettype none
module lmu_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lmu_pkg::job_t             job,
	input  wire logic                      job_valid,
	output logic                           job_pop,
	input  wire lmu_pkg::mat_t             extr_rot,
	input  wire lmu_pkg::vec3_t            extr_t,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [lmu_pkg::VEC_W-1:0]      out_x,
	output logic [lmu_pkg::VEC_W-1:0]      out_y,
	output logic [lmu_pkg::VEC_W-1:0]      out_z,
	output logic                           compensated
);
	import lmu_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RUN  = 2'd1;
	localparam logic [1:0] B_FIN  = 2'd2;

	localparam logic [1:0] OP_EXTR  = 2'd0;
	localparam logic [1:0] OP_POSE  = 2'd1;
	localparam logic [1:0] OP_WORLD = 2'd2;
	localparam logic [1:0] OP_BACK  = 2'd3;
	localparam logic [1:0] ROW_DONE = 2'd3;

	logic [1:0]  bst_q;
	job_t        job_q;
	vec3_t       v_q;
	vec3_t       n_q;
	logic [1:0]  op_q;
	logic [1:0]  row_q;
	logic        comp_q;
	logic        acc_v_s1;
	logic [1:0]  acc_row_s1;
	logic [2:0][PROD_W-1:0] prod_s1;

	logic        out_valid_q;
	vec3_t       out_q;
	logic        out_comp_q;

	mat_t                m_sel;
	logic                tr;
	logic [SUM_W-1:0]    sum;
	logic [VEC_W-1:0]    dot;
	logic [VEC_W-1:0]    res;
	logic                load_out;

	// full-width signed product of a Q1.16 entry and a Q15.16 coordinate
	function automatic logic [PROD_W-1:0] mul_elem(logic signed [ELEM_W-1:0] e,
			logic signed [VEC_W-1:0] v);
		logic signed [PROD_W-1:0] ee;
		logic signed [PROD_W-1:0] ve;
		ee = e;
		ve = v;
		return ee * ve;
	endfunction

	always_comb begin
		case (op_q)
			OP_EXTR:  begin m_sel = extr_rot;     tr = 1'b0; end
			OP_POSE:  begin m_sel = job_q.pk.rot; tr = 1'b0; end
			OP_WORLD: begin m_sel = job_q.pw.rot; tr = 1'b1; end
			default:  begin m_sel = extr_rot;     tr = 1'b1; end
		endcase
	end

	// round half up, floor of the shift, then saturate
	always_comb begin
		sum = SUM_W'($signed(prod_s1[0])) + SUM_W'($signed(prod_s1[1]))
			+ SUM_W'($signed(prod_s1[2])) + SUM_W'(32768);
		dot = sat_narrow(sum[SUM_W-1:16]);
		case (op_q)
			OP_EXTR:  res = sat_add(dot, extr_t[acc_row_s1], 1'b0);
			OP_POSE:  res = sat_add(sat_add(dot, job_q.pk.trans[acc_row_s1], 1'b0),
				job_q.pw.trans[acc_row_s1], 1'b1);
			OP_WORLD: res = sat_add(dot, extr_t[acc_row_s1], 1'b1);
			default:  res = dot;
		endcase
	end

	assign job_pop  = (bst_q == B_IDLE) && job_valid;
	assign load_out = (bst_q == B_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job;
		if (bst_q == B_RUN && row_q != ROW_DONE) begin
			for (int j = 0; j < 3; j++)
				prod_s1[j] <= mul_elem(mat_elem(m_sel, row_q, 2'(j), tr), v_q[j]);
			acc_row_s1 <= row_q;
		end
		if (job_pop)
			v_q <= job.pt;
		else if (acc_v_s1) begin
			if (acc_row_s1 == 2'd2)
				v_q <= {res, n_q[1], n_q[0]};
			else
				n_q[acc_row_s1] <= res;
		end
		if (load_out) begin
			out_q      <= v_q;
			out_comp_q <= comp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_IDLE;
			op_q        <= OP_EXTR;
			row_q       <= '0;
			comp_q      <= 1'b0;
			acc_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_v_s1 <= (bst_q == B_RUN) && (row_q != ROW_DONE);
			case (bst_q)
				B_IDLE: begin
					if (job_valid) begin
						comp_q <= job.comp;
						op_q   <= OP_EXTR;
						row_q  <= '0;
						bst_q  <= job.comp ? B_RUN : B_FIN;
					end
				end
				B_RUN: begin
					if (row_q != ROW_DONE)
						row_q <= row_q + 1'b1;
					if (acc_v_s1 && acc_row_s1 == 2'd2) begin
						row_q <= '0;
						op_q  <= op_q + 1'b1;
						if (op_q == OP_BACK)
							bst_q <= B_FIN;
					end
				end
				B_FIN: begin
					if (load_out)
						bst_q <= B_IDLE;
				end
				default: bst_q <= B_IDLE;
			endcase
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_q[0];
	assign out_y       = out_q[1];
	assign out_z       = out_q[2];
	assign compensated = out_comp_q;

	a_acc_row_ok: assert property (@(posedge clk) disable iff (!arst_n)
			acc_v_s1 |-> acc_row_s1 != ROW_DONE)
		else $error("row accumulate out of range");
	a_run_has_comp: assert property (@(posedge clk) disable iff (!arst_n)
			bst_q == B_RUN |-> comp_q)
		else $error("pass-through point entered transform");
endmodule
`default_nettype wire

// ===== sv/lidar_motion_undistortion.sv =====
// Lidar motion compensation against a table of poses.
// Input channel (in_valid/in_ready): each transaction is one item selected
// by action: start scan (empties the pose table), append pose (rotation
// rows, translation in vec_*, absolute stamp), or process point (vec_* and
// stamp in microseconds since scan start). Point transactions produce one
// output transaction (out_valid/out_ready); others produce none.
// Config: cfg_we/cfg_index/cfg_data writes the extrinsic and scan start;
// the user must write only while the block is idle, which goes unchecked.
// A point is accepted, compared against the stored poses (a read and a
// compare per pose, only a read if the table is empty) and pushed in the
// front, then the back end pops it, transforms it and loads the output
// register. In the transform one three-multiplier row unit evaluates the
// four matrix-vector products one row per cycle. Throughput of compensated
// points is set by that shared row unit; the front runs ahead through a
// two-entry job queue.
// Reset empties the pose table, clears the extrinsic and scan start to zero
// and drops any queued work. If out_ready is low the result stays in the
// output register; the back end then holds and the queue fills, after which
// the front stops accepting transactions.
`default_nettype none
module lidar_motion_undistortion #(
	parameter int POSE_DEPTH = lmu_pkg::POSE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [lmu_pkg::ACT_W-1:0]        action,
	input  wire logic [lmu_pkg::ROW_W-1:0]        rot_row0,
	input  wire logic [lmu_pkg::ROW_W-1:0]        rot_row1,
	input  wire logic [lmu_pkg::ROW_W-1:0]        rot_row2,
	input  wire logic signed [lmu_pkg::VEC_W-1:0] vec_x,
	input  wire logic signed [lmu_pkg::VEC_W-1:0] vec_y,
	input  wire logic signed [lmu_pkg::VEC_W-1:0] vec_z,
	input  wire logic [lmu_pkg::STAMP_W-1:0]      stamp,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [lmu_pkg::VEC_W-1:0]      out_x,
	output logic signed [lmu_pkg::VEC_W-1:0]      out_y,
	output logic signed [lmu_pkg::VEC_W-1:0]      out_z,
	output logic                                  compensated,
	input  wire logic                             cfg_we,
	input  wire logic [lmu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lmu_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lmu_pkg::*;

	// extrinsic and scan start
	mat_t               extr_rot_q;
	vec3_t              extr_t_q;
	logic [STAMP_W-1:0] scan_begin_q;

	pose_t in_pose;
	job_t  f_job;
	job_t  q_job;
	logic  f_push;
	logic  q_full;
	logic  q_not_empty;
	logic  b_pop;
	logic [VEC_W-1:0] bx, by, bz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extr_rot_q   <= '0;
			extr_t_q     <= '0;
			scan_begin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT0:  extr_rot_q[0] <= cfg_data[ROW_W-1:0];
				REG_ROT1:  extr_rot_q[1] <= cfg_data[ROW_W-1:0];
				REG_ROT2:  extr_rot_q[2] <= cfg_data[ROW_W-1:0];
				REG_TX:    extr_t_q[0]   <= cfg_data[VEC_W-1:0];
				REG_TY:    extr_t_q[1]   <= cfg_data[VEC_W-1:0];
				REG_TZ:    extr_t_q[2]   <= cfg_data[VEC_W-1:0];
				REG_BEGIN: scan_begin_q  <= cfg_data[STAMP_W-1:0];
				default: ;
			endcase
		end
	end

	// one bundle serves both pose appends and points
	always_comb begin
		in_pose.rot   = {rot_row2, rot_row1, rot_row0};
		in_pose.trans = {vec_z, vec_y, vec_x};
	end

	lmu_front #(.POSE_DEPTH(POSE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.in_pose   (in_pose),
		.stamp     (stamp),
		.scan_begin(scan_begin_q),
		.push      (f_push),
		.job       (f_job),
		.q_full    (q_full)
	);

	lmu_fifo #(.WIDTH($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.wdata    (f_job),
		.full     (q_full),
		.pop      (b_pop),
		.rdata    (q_job),
		.not_empty(q_not_empty)
	);

	lmu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (q_job),
		.job_valid  (q_not_empty),
		.job_pop    (b_pop),
		.extr_rot   (extr_rot_q),
		.extr_t     (extr_t_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (bx),
		.out_y      (by),
		.out_z      (bz),
		.compensated(compensated)
	);

	assign out_x = $signed(bx);
	assign out_y = $signed(by);
	assign out_z = $signed(bz);
endmodule
`default_nettype wire
